// ===== hdl/pulse_oximeter_window_spo2_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the SpO2 window unit
// ---------------------------------------------------------------------------
`ifndef PULSE_OXIMETER_WINDOW_SPO2_UNIT_MACROS_SVH
`define PULSE_OXIMETER_WINDOW_SPO2_UNIT_MACROS_SVH

// implication checked on every edge outside reset
`define POX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define POX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/pox_pkg.sv =====
// ---------------------------------------------------------------------------
// pox_pkg
// Shared types and constants for the SpO2 window unit.
// ---------------------------------------------------------------------------
package pox_pkg;

	localparam int unsigned SW = 18;
	localparam int unsigned PW = 7;

	localparam logic [1:0] REG_AC   = 2'd0;
	localparam logic [1:0] REG_DC   = 2'd1;
	localparam logic [1:0] REG_GOOD = 2'd2;

	localparam logic [SW-1:0] AC_RESET   = 18'd50;
	localparam logic [SW-1:0] DC_RESET   = 18'd5000;
	localparam logic [SW-1:0] GOOD_RESET = 18'd5000;

	localparam logic [PW-1:0] SPO2_BASE = 7'd110;
	localparam logic [PW-1:0] SPO2_LOW  = 7'd90;
	localparam logic [PW-1:0] SPO2_HIGH = 7'd100;
	localparam logic [4:0]    RATIO_K   = 5'd20;

	// job from front to back
	typedef struct packed {
		logic [SW-1:0] ir_dc;
		logic [SW-1:0] red_dc;
		logic [SW-1:0] ir_ac;
		logic [SW-1:0] red_ac;
		logic          use_ratio;
		logic          valid_spo2;
		logic          good;
	} job_t;

	typedef struct packed {
		logic [SW-1:0] ir_dc;
		logic [SW-1:0] red_dc;
		logic [SW-1:0] ir_ac;
		logic [SW-1:0] red_ac;
		logic [PW-1:0] spo2;
		logic          good;
	} res_t;

endpackage

// ===== hdl/pox_front.sv =====
// ---------------------------------------------------------------------------
// pox_front
// Window store and scan: sum, min and max over the window, one entry a cycle.
// ---------------------------------------------------------------------------
module pox_front #(
	parameter int unsigned WINDOW_LEN = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [pox_pkg::SW-1:0] ir_sample,
	input  logic [pox_pkg::SW-1:0] red_sample,
	input  logic [pox_pkg::SW-1:0] ac_thr,
	input  logic [pox_pkg::SW-1:0] dc_thr,
	input  logic [pox_pkg::SW-1:0] good_thr,
	output logic                   job_valid,
	input  logic                   job_ready,
	output pox_pkg::job_t          job
);
	localparam int unsigned AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int unsigned CW = $clog2(WINDOW_LEN + 1);
	localparam int unsigned SUMW = pox_pkg::SW + $clog2(WINDOW_LEN + 1);
	// mean by reciprocal multiplication, exact for every sum below 2**SUMW
	localparam int unsigned RS = SUMW + AW;
	localparam int unsigned MW = SUMW + 1;
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << RS) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]             state_q;
	logic [pox_pkg::SW-1:0] ir_mem [WINDOW_LEN];
	logic [pox_pkg::SW-1:0] red_mem [WINDOW_LEN];
	logic [AW-1:0]          slot_q;
	logic [CW-1:0]          fill_q;
	logic [CW-1:0]          idx_q;
	logic [SUMW-1:0]        ir_sum_q, red_sum_q;
	logic [pox_pkg::SW-1:0] ir_max_q, ir_min_q, red_max_q, red_min_q;
	logic [pox_pkg::SW-1:0] ir_dc_q, red_dc_q;
	logic                   good_q;
	logic [pox_pkg::SW-1:0] ir_rd_q, red_rd_q;
	logic [SUMW+MW-1:0]     ir_prod, red_prod;
	logic [pox_pkg::SW-1:0] ir_ac_w, red_ac_w;
	logic                   nofinger;

	assign full = (state_q != ST_IDLE);

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ir_mem[slot_q]  <= ir_sample;
			red_mem[slot_q] <= red_sample;
		end
		// entries never written since reset read as zero
		ir_rd_q  <= (idx_q < fill_q) ? ir_mem[idx_q[AW-1:0]] : '0;
		red_rd_q <= (idx_q < fill_q) ? red_mem[idx_q[AW-1:0]] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			fill_q  <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (push) begin
						state_q <= ST_SCAN;
						slot_q  <= (slot_q == AW'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
						if (fill_q != CW'(WINDOW_LEN))
							fill_q <= fill_q + 1'b1;
						idx_q <= '0;
					end
				end
				ST_SCAN: begin
					// read data is registered, so it lags the index
					if (idx_q == CW'(WINDOW_LEN))
						state_q <= ST_DIV;
					else
						idx_q <= idx_q + 1'b1;
				end
				ST_DIV: state_q <= ST_OUT;
				ST_OUT: if (job_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign ir_prod  = (SUMW+MW)'(ir_sum_q) * (SUMW+MW)'(RECIP);
	assign red_prod = (SUMW+MW)'(red_sum_q) * (SUMW+MW)'(RECIP);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			ir_sum_q  <= '0;
			red_sum_q <= '0;
			ir_max_q  <= '0;
			red_max_q <= '0;
			ir_min_q  <= '1;
			red_min_q <= '1;
			good_q    <= (ir_sample > good_thr);
		end else if (state_q == ST_SCAN) begin
			if (idx_q != '0) begin
				ir_sum_q  <= ir_sum_q + SUMW'(ir_rd_q);
				red_sum_q <= red_sum_q + SUMW'(red_rd_q);
				if (ir_rd_q > ir_max_q) ir_max_q <= ir_rd_q;
				if (ir_rd_q < ir_min_q) ir_min_q <= ir_rd_q;
				if (red_rd_q > red_max_q) red_max_q <= red_rd_q;
				if (red_rd_q < red_min_q) red_min_q <= red_rd_q;
			end
		end else if (state_q == ST_DIV) begin
			ir_dc_q  <= pox_pkg::SW'(ir_prod >> RS);
			red_dc_q <= pox_pkg::SW'(red_prod >> RS);
		end
	end

	assign ir_ac_w  = ir_max_q - ir_min_q;
	assign red_ac_w = red_max_q - red_min_q;
	assign nofinger = (ir_ac_w < ac_thr) || (ir_dc_q < dc_thr);

	assign job_valid       = (state_q == ST_OUT);
	assign job.ir_dc       = ir_dc_q;
	assign job.red_dc      = red_dc_q;
	assign job.ir_ac       = nofinger ? '0 : ir_ac_w;
	assign job.red_ac      = nofinger ? '0 : red_ac_w;
	assign job.valid_spo2  = !nofinger && (ir_ac_w > ac_thr);
	assign job.use_ratio   = (red_ac_w != '0) && (ir_ac_w != '0)
		&& (red_dc_q > dc_thr) && (ir_dc_q > dc_thr);
	assign job.good        = good_q;
endmodule

// ===== hdl/pox_back.sv =====
// ---------------------------------------------------------------------------
// pox_back
// Ratio unit: products, restoring division, clamp; one-entry result register.
// ---------------------------------------------------------------------------
module pox_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  pox_pkg::job_t job,
	output logic          empty,
	input  logic          pop,
	output pox_pkg::res_t res
);
	localparam int unsigned PRW = 2 * pox_pkg::SW;
	localparam int unsigned NW  = PRW + 5;
	localparam int unsigned QW  = 7;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_PRE  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_HOLD = 3'd5;

	logic [2:0]      state_q;
	pox_pkg::job_t   job_q;
	logic [PRW-1:0]  num_q, den_q;
	logic [NW-1:0]   dividend_q;
	logic [NW:0]     rem_q;
	logic [QW:0]     quo_q;
	logic [5:0]      cnt_q;
	logic            sat_q;
	logic [NW:0]     rem_sh;
	logic [NW:0]     rem_sub;
	logic [pox_pkg::PW-1:0] spo2_w;
	logic [pox_pkg::PW-1:0] spo2_q;

	assign job_ready = (state_q == ST_IDLE);
	assign empty     = (state_q != ST_HOLD);

	assign rem_sh  = {rem_q[NW-1:0], dividend_q[NW-1]};
	assign rem_sub = rem_sh - {1'b0, 5'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (job_valid) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_PRE;
				ST_PRE: begin
					state_q <= ST_DIV;
					cnt_q   <= 6'(NW - 1);
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= ST_FIN;
				end
				ST_FIN:  state_q <= ST_HOLD;
				ST_HOLD: if (pop) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: job_q <= job;
			ST_MUL: begin
				if (job_q.use_ratio) begin
					num_q <= job_q.red_ac * job_q.ir_dc;
					den_q <= job_q.red_dc * job_q.ir_ac;
				end else begin
					num_q <= PRW'(1);
					den_q <= PRW'(1);
				end
			end
			ST_PRE: begin
				// ceil(20n/d) = floor((20n + d - 1)/d)
				dividend_q <= NW'(num_q) * NW'(pox_pkg::RATIO_K) + NW'(den_q) - NW'(1);
				rem_q      <= '0;
				quo_q      <= '0;
				sat_q      <= 1'b0;
			end
			ST_DIV: begin
				dividend_q <= {dividend_q[NW-2:0], 1'b0};
				if (!rem_sub[NW]) begin
					rem_q <= rem_sub;
					if (quo_q[QW]) sat_q <= 1'b1;
					quo_q <= {quo_q[QW-1:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					if (quo_q[QW]) sat_q <= 1'b1;
					quo_q <= {quo_q[QW-1:0], 1'b0};
				end
			end
			ST_FIN: spo2_q <= spo2_w;
			default: ;
		endcase
	end

	always_comb begin
		if (!job_q.valid_spo2)
			spo2_w = '0;
		else if (sat_q || quo_q >= (QW+1)'(pox_pkg::SPO2_BASE))
			spo2_w = '0;
		else if (pox_pkg::SPO2_BASE - quo_q[QW-1:0] < pox_pkg::SPO2_LOW)
			spo2_w = pox_pkg::SPO2_LOW;
		else if (pox_pkg::SPO2_BASE - quo_q[QW-1:0] > pox_pkg::SPO2_HIGH)
			spo2_w = pox_pkg::SPO2_HIGH;
		else
			spo2_w = pox_pkg::SPO2_BASE - quo_q[QW-1:0];
	end

	assign res.ir_dc  = job_q.ir_dc;
	assign res.red_dc = job_q.red_dc;
	assign res.ir_ac  = job_q.ir_ac;
	assign res.red_ac = job_q.red_ac;
	assign res.spo2   = spo2_q;
	assign res.good   = job_q.good;
endmodule

// ===== hdl/pulse_oximeter_window_spo2_unit.sv =====
// ---------------------------------------------------------------------------
// pulse_oximeter_window_spo2_unit
// Windowed DC/AC levels and ratio-of-ratios SpO2 per IR/red sample pair.
// ---------------------------------------------------------------------------
// channel  | handshake   | beat
// input    | push/full   | ir_sample, red_sample
// result   | pop/empty   | ir_dc, red_dc, ir_ac, red_ac, spo2_percent, signal_good
// config   | cfg_we      | cfg_index, cfg_data
// Front: registered scan of the window store; takes no new beat until the job is out.
// Back: 41-step divider over the ratio products, then a hold until pop.
// Front and back overlap; throughput is set by the slower of the two and by pop.
// Reset sets thresholds to defaults and empties the window; old entries read as zero.
// A stalled pop holds the back; the front holds its finished job and keeps full high.
// ---------------------------------------------------------------------------
module pulse_oximeter_window_spo2_unit #(
	parameter int unsigned WINDOW_LEN = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [pox_pkg::SW-1:0]      ir_sample,
	input  logic [pox_pkg::SW-1:0]      red_sample,
	output logic                        empty,
	input  logic                        pop,
	output logic [pox_pkg::SW-1:0]      ir_dc,
	output logic [pox_pkg::SW-1:0]      red_dc,
	output logic [pox_pkg::SW-1:0]      ir_ac,
	output logic [pox_pkg::SW-1:0]      red_ac,
	output logic [pox_pkg::PW-1:0]      spo2_percent,
	output logic                        signal_good,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [pox_pkg::SW-1:0]      cfg_data
);
	logic [pox_pkg::SW-1:0] ac_thr_q, dc_thr_q, good_thr_q;
	logic                   job_valid, job_ready;
	pox_pkg::job_t          job;
	pox_pkg::res_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac_thr_q   <= pox_pkg::AC_RESET;
			dc_thr_q   <= pox_pkg::DC_RESET;
			good_thr_q <= pox_pkg::GOOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pox_pkg::REG_AC:   ac_thr_q   <= cfg_data;
				pox_pkg::REG_DC:   dc_thr_q   <= cfg_data;
				pox_pkg::REG_GOOD: good_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pox_front #(.WINDOW_LEN(WINDOW_LEN)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.ir_sample(ir_sample), .red_sample(red_sample),
		.ac_thr(ac_thr_q), .dc_thr(dc_thr_q), .good_thr(good_thr_q),
		.job_valid(job_valid), .job_ready(job_ready), .job(job)
	);

	pox_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_ready(job_ready),
		.job(job), .empty(empty), .pop(pop), .res(res)
	);

	assign ir_dc        = res.ir_dc;
	assign red_dc       = res.red_dc;
	assign ir_ac        = res.ir_ac;
	assign red_ac       = res.red_ac;
	assign spo2_percent = res.spo2;
	assign signal_good  = res.good;
endmodule

// ===== hdl/pox_checker.sv =====
// ---------------------------------------------------------------------------
// pox_checker
// Port-level checks on the SpO2 window unit.
// ---------------------------------------------------------------------------
`include "pulse_oximeter_window_spo2_unit_macros.svh"

module pox_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [6:0] spo2_percent,
	input logic [17:0] ir_ac
);
	logic spo2_ok;

	assign spo2_ok = (spo2_percent == 7'd0)
		|| (spo2_percent >= 7'd90 && spo2_percent <= 7'd100);

	`POX_ASSERT_IMP(a_spo2_range, clk, arst_n, !empty, spo2_ok)
	`POX_ASSERT_IMP(a_nofinger, clk, arst_n, !empty && ir_ac == 18'd0, spo2_percent == 7'd0)
	`POX_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(spo2_percent))
endmodule

bind pulse_oximeter_window_spo2_unit pox_checker u_pox_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.spo2_percent(spo2_percent), .ir_ac(ir_ac)
);
